[rtl/core/ppmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_pkg: shared types, constants and helpers of the PPM channel decoder
// Holds the payload structs, register indexes, channel roles and the
// width-to-value mapping used by the decoder core.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  // Geometry
  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned WIDTH_BITS = 16;
  localparam int unsigned JIT_W      = 10;
  localparam int unsigned NORM_W     = 8;
  localparam int unsigned D_W        = 10;

  // Linear map window and reset widths
  localparam logic [WIDTH_BITS-1:0] MAP_LO       = 16'd984;
  localparam logic [WIDTH_BITS-1:0] MAP_HI       = 16'd1999;
  localparam logic [WIDTH_BITS-1:0] STICK_CENTER = 16'd1500;
  localparam logic [WIDTH_BITS-1:0] RESET_OTHER  = 16'd984;
  localparam logic [D_W-1:0]        D_MAX        = 10'd1015;

  // floor(d * 200 / 1015) == (d * MAP_K) >> MAP_SHIFT for d in 0..1015
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned MAP_SHIFT = 24;
  localparam int unsigned Q_W       = 8;
  localparam logic [21:0] MAP_K     = 22'd3305880;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT_SYNC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THR  = 3'd5;

  // Channel roles by slot
  localparam logic [CH_W-1:0] ROLE_ROLL     = 3'd0;
  localparam logic [CH_W-1:0] ROLE_PITCH    = 3'd1;
  localparam logic [CH_W-1:0] ROLE_THROTTLE = 3'd2;
  localparam logic [CH_W-1:0] ROLE_YAW      = 3'd3;
  localparam logic [CH_W-1:0] ROLE_SW_A     = 3'd4;
  localparam logic [CH_W-1:0] ROLE_SW_B     = 3'd5;
  localparam logic [CH_W-1:0] ROLE_VR       = 3'd6;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [WIDTH_BITS-1:0] gap_us;
    logic [CH_W-1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] value;
    logic                     fresh;
    logic                     frame_error;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] sync_gap;
    logic [WIDTH_BITS-1:0] valid_min;
    logic [WIDTH_BITS-1:0] valid_max;
    logic [JIT_W-1:0]      jitter_limit;
    logic                  strict_sync;
    logic [WIDTH_BITS-1:0] switch_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sync_gap:         16'd3000,
    valid_min:        16'd984,
    valid_max:        16'd1999,
    jitter_limit:     10'd20,
    strict_sync:      1'b1,
    switch_threshold: 16'd1000
  };

  // Clamp a width into the map window and return its offset from the low end
  function automatic logic [D_W-1:0] width_to_d(input logic [WIDTH_BITS-1:0] w);
    logic [WIDTH_BITS-1:0] off;
    off = w - MAP_LO;
    if (w <= MAP_LO) begin
      return '0;
    end else if (w >= MAP_HI) begin
      return D_MAX;
    end else begin
      return off[D_W-1:0];
    end
  endfunction

  // Last accepted width after reset
  function automatic logic [WIDTH_BITS-1:0] acc_reset(input logic [CH_W-1:0] ch);
    logic [WIDTH_BITS-1:0] r;
    case (ch) inside
      ROLE_ROLL, ROLE_PITCH, ROLE_YAW: r = STICK_CENTER;
      default:                         r = RESET_OTHER;
    endcase
    return r;
  endfunction

  // Map a scaled quotient (0..200) or switch level to the role's value
  function automatic logic signed [NORM_W-1:0] norm_map(
    input logic [CH_W-1:0]          ch,
    input logic [Q_W-1:0]           q,
    input logic                     hi,
    input logic signed [NORM_W-1:0] held
  );
    logic signed [NORM_W:0]   qs;
    logic signed [NORM_W-1:0] r;
    qs = $signed({1'b0, q});
    unique case (ch) inside
      ROLE_ROLL, ROLE_YAW:     r = NORM_W'(qs - 9'sd100);
      ROLE_PITCH:              r = NORM_W'(9'sd100 - qs);
      ROLE_THROTTLE, ROLE_VR:  r = $signed({1'b0, q[Q_W-1:1]});
      ROLE_SW_A:               r = hi ? 8'sd0 : 8'sd1;
      ROLE_SW_B:               r = hi ? 8'sd1 : 8'sd100;
      default:                 r = held;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ppmd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_cfg: configuration registers of the PPM channel decoder
// Decodes the plain write port into the six decoder settings.
// ----------------------------------------------------------------------------
module ppmd_cfg import ppmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_GAP:    cfg_d.sync_gap         = cfg_data_i[WIDTH_BITS-1:0];
        CFG_VALID_MIN:   cfg_d.valid_min        = cfg_data_i[WIDTH_BITS-1:0];
        CFG_VALID_MAX:   cfg_d.valid_max        = cfg_data_i[WIDTH_BITS-1:0];
        CFG_JITTER:      cfg_d.jitter_limit     = cfg_data_i[JIT_W-1:0];
        CFG_STRICT_SYNC: cfg_d.strict_sync      = cfg_data_i[0];
        CFG_SWITCH_THR:  cfg_d.switch_threshold = cfg_data_i[WIDTH_BITS-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/ppm_channel_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_channel_decoder: RC PPM stream decoder
// Edge items fill channel width slots between frame syncs; read items check
// a slot's width and return its normalized value.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//  out     | out       | out_valid_o / out_ready_i | out_item_o (out_item_t)
//
// One item is taken per cycle while input ready is high. Edge items finish at
// the transfer edge and give no result; a read's result enters the output
// register when stage 1 advances, after one pass through the channel memory
// read-modify-write. Reset needs no clearing pass: per-entry valid bits supply
// reset contents. Input ready drops only while the output register is full and
// not taken with a read waiting behind it.
// ----------------------------------------------------------------------------
module ppm_channel_decoder import ppmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  typedef struct packed {
    logic [WIDTH_BITS-1:0] width;
    logic [D_W-1:0]        d;
  } wslot_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]    acc;
    logic signed [NORM_W-1:0] norm;
  } cslot_t;

  cfg_t cfg;

  ppmd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake
  logic in_xfer, rd_xfer, edge_xfer, s1_adv;
  logic s1_vld_q, s1_vld_d, out_vld_q, out_vld_d;

  assign in_ready_o = !s1_vld_q || !out_vld_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign rd_xfer    = in_xfer && (in_item_i.op == OP_READ);
  assign edge_xfer  = in_xfer && (in_item_i.op == OP_EDGE);
  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);

  // Frame tracking on edge transfers
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              err_q, err_d;
  logic              is_sync, early, wmem_we;
  logic [CH_W-1:0]   wmem_wa, rd_a;

  assign is_sync = in_item_i.gap_us > cfg.sync_gap;
  assign early   = slot_q < SLOT_W'(CHANNELS);
  assign wmem_wa = slot_q[CH_W-1:0];
  assign rd_a    = in_item_i.channel;

  always_comb begin
    slot_d  = slot_q;
    err_d   = err_q;
    wmem_we = 1'b0;
    if (edge_xfer) begin
      if (is_sync) begin
        if (cfg.strict_sync && early) begin
          err_d = 1'b1;
        end else begin
          err_d  = early;
          slot_d = '0;
        end
      end else if (early) begin
        wmem_we = 1'b1;
        slot_d  = slot_q + SLOT_W'(1);
      end
    end
  end

  // Width memory: written by edges, read by reads
  wslot_t                wmem [CHANNELS];
  wslot_t                wrd_q;
  logic                  wrd_vld_q;
  logic [CHANNELS-1:0]   wvld_q;

  always_ff @(posedge clk_i) begin
    if (wmem_we) begin
      wmem[wmem_wa] <= '{width: in_item_i.gap_us,
                         d:     width_to_d(in_item_i.gap_us)};
    end
    if (rd_xfer) begin
      wrd_q     <= wmem[rd_a];
      wrd_vld_q <= wvld_q[rd_a];
    end
  end

  // Channel memory: accepted width and normalized value, read-modify-write
  cslot_t                cmem [CHANNELS];
  cslot_t                crd_q;
  logic                  crd_vld_q;
  logic [CHANNELS-1:0]   cvld_q;
  logic                  cmem_we;
  cslot_t                cmem_wd;

  // Stage 1 item info
  logic [CH_W-1:0] s1_ch_q;
  logic            s1_ok_q, s1_err_q;

  // Last channel write, forwarded to a read that overlapped it
  logic            fwd_vld_q;
  logic [CH_W-1:0] fwd_ch_q;
  cslot_t          fwd_q;

  always_ff @(posedge clk_i) begin
    if (cmem_we) begin
      cmem[s1_ch_q] <= cmem_wd;
      fwd_ch_q      <= s1_ch_q;
      fwd_q         <= cmem_wd;
    end
    if (rd_xfer) begin
      crd_q     <= cmem[rd_a];
      crd_vld_q <= cvld_q[rd_a];
      s1_ch_q   <= rd_a;
      s1_ok_q   <= {1'b0, in_item_i.channel} < SLOT_W'(CHANNELS);
      s1_err_q  <= err_q;
    end
  end

  // Stage 1: check the width and map it
  logic [WIDTH_BITS-1:0]    w_cur, diff;
  logic [D_W-1:0]           d_cur;
  cslot_t                   c_cur;
  logic                     pass, w_hi;
  logic [PROD_W-1:0]        prod;
  logic [Q_W-1:0]           q;
  logic signed [NORM_W-1:0] new_norm, value;

  always_comb begin
    w_cur = wrd_vld_q ? wrd_q.width : '0;
    d_cur = wrd_vld_q ? wrd_q.d : '0;
    if (fwd_vld_q && (fwd_ch_q == s1_ch_q)) begin
      c_cur = fwd_q;
    end else if (crd_vld_q) begin
      c_cur = crd_q;
    end else begin
      c_cur = '{acc: acc_reset(s1_ch_q), norm: '0};
    end
  end

  assign diff = (c_cur.acc > w_cur) ? (c_cur.acc - w_cur) : (w_cur - c_cur.acc);
  assign pass = s1_ok_q && (w_cur > cfg.valid_min) && (w_cur < cfg.valid_max)
             && (diff < WIDTH_BITS'(cfg.jitter_limit));
  assign prod = PROD_W'(d_cur) * PROD_W'(MAP_K);
  assign q    = prod[MAP_SHIFT +: Q_W];
  assign w_hi = w_cur > cfg.switch_threshold;

  assign new_norm = norm_map(s1_ch_q, q, w_hi, c_cur.norm);
  assign value    = !s1_ok_q ? '0 : (pass ? new_norm : c_cur.norm);
  assign cmem_we  = s1_adv && pass;
  assign cmem_wd  = '{acc: w_cur, norm: new_norm};

  // Output register
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= '{value: value, fresh: pass, frame_error: s1_err_q};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Advance the stage and output valid flags
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (rd_xfer) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      err_q     <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      wvld_q    <= '0;
      cvld_q    <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      err_q     <= err_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (wmem_we) begin
        wvld_q[wmem_wa] <= 1'b1;
      end
      if (cmem_we) begin
        cvld_q[s1_ch_q] <= 1'b1;
        fwd_vld_q       <= 1'b1;
      end
    end
  end

  // Assertions
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_item_o.value) >= -8'sd100)
                 && ($signed(out_item_o.value) <= 8'sd100))
    else $error("normalized value out of range");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(CHANNELS))
    else $error("slot index beyond channel count");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_vld_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a full output");

  a_write_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmem_we |=> fwd_vld_q && (fwd_ch_q == $past(s1_ch_q)))
    else $error("channel write not captured for forwarding");

endmodule

[dv/ppm_channel_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_channel_decoder_tb: self-checking bench for the PPM channel decoder
// Drives edge and read items over valid/ready with random gaps, rewrites the
// register set between phases, and compares every readout field by field
// against an internal decoder model. A directed table walks reset values,
// extreme widths and the frame sync cases; random PPM frames follow.
// ----------------------------------------------------------------------------
module ppm_channel_decoder_tb import ppmd_pkg::*; ();

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned N_DIR       = 26;
  localparam int unsigned N_PHASES    = 10;

  localparam out_item_t RES_CLEAN = '{value: 8'sd0, fresh: 1'b0, frame_error: 1'b0};
  localparam out_item_t RES_ERR   = '{value: 8'sd0, fresh: 1'b0, frame_error: 1'b1};

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;

  // Decoder model state
  cfg_t                     cfg_q;
  logic [WIDTH_BITS-1:0]    slot_width [CHANNELS];
  logic [WIDTH_BITS-1:0]    last_good  [CHANNELS];
  logic signed [NORM_W-1:0] held_val   [CHANNELS];
  int unsigned              fill_idx;
  bit                       sync_err;

  out_item_t   readout_q [$];
  dir_row_t    dir_rows [N_DIR];

  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;
  int unsigned quiet_cycles;
  int unsigned n_items, n_edges, n_reads, n_fresh, n_checked, n_stalls, n_fail;

  ppm_channel_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // Model: reset contents
  task automatic reset_model();
    cfg_q    = CFG_RESET;
    fill_idx = 0;
    sync_err = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      slot_width[i] = '0;
      held_val[i]   = '0;
      last_good[i]  = (i == ROLE_ROLL || i == ROLE_PITCH || i == ROLE_YAW) ?
                      STICK_CENTER : RESET_OTHER;
    end
  endtask

  // Linear width map, truncating division, saturated to the role range
  function automatic logic signed [NORM_W-1:0] scale_width(
    input logic [WIDTH_BITS-1:0] w, input int lo, input int hi);
    int r;
    int bot;
    int top;
    r   = ((int'(w) - int'(MAP_LO)) * (hi - lo)) / (int'(MAP_HI) - int'(MAP_LO)) + lo;
    bot = (lo < hi) ? lo : hi;
    top = (lo < hi) ? hi : lo;
    if (r < bot) r = bot;
    if (r > top) r = top;
    return r[NORM_W-1:0];
  endfunction

  // Model: advance state by one accepted item and queue its readout
  task automatic decode_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t             res;
    logic [WIDTH_BITS-1:0] w;
    logic [WIDTH_BITS-1:0] acc;
    int unsigned           diff;
    bit                    ok;
    if (it.op == OP_EDGE) begin
      n_edges++;
      if (it.gap_us > cfg_q.sync_gap) begin
        if (cfg_q.strict_sync && fill_idx < CHANNELS) begin
          sync_err = 1'b1;
        end else begin
          sync_err = (fill_idx < CHANNELS);
          fill_idx = 0;
        end
      end else if (fill_idx < CHANNELS) begin
        slot_width[fill_idx] = it.gap_us;
        fill_idx++;
      end
    end else begin
      n_reads++;
      w    = slot_width[it.channel];
      acc  = last_good[it.channel];
      diff = (acc > w) ? acc - w : w - acc;
      ok   = (w > cfg_q.valid_min) && (w < cfg_q.valid_max) && (diff < cfg_q.jitter_limit);
      if (ok) begin
        n_fresh++;
        last_good[it.channel] = w;
        case (it.channel)
          ROLE_ROLL, ROLE_YAW:    held_val[it.channel] = scale_width(w, -100, 100);
          ROLE_PITCH:             held_val[it.channel] = scale_width(w, 100, -100);
          ROLE_THROTTLE, ROLE_VR: held_val[it.channel] = scale_width(w, 0, 100);
          ROLE_SW_A: held_val[it.channel] = (w > cfg_q.switch_threshold) ? 8'sd0 : 8'sd1;
          ROLE_SW_B: held_val[it.channel] = (w > cfg_q.switch_threshold) ? 8'sd1 : 8'sd100;
          default: ;
        endcase
      end
      res.value       = held_val[it.channel];
      res.fresh       = ok;
      res.frame_error = sync_err;
      readout_q.push_back(typed ? want : res);
    end
  endtask

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
  endfunction

  function automatic in_item_t edge_item(input logic [WIDTH_BITS-1:0] pw);
    in_item_t it;
    it.op      = OP_EDGE;
    it.gap_us  = pw;
    it.channel = 3'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [CH_W-1:0] ch);
    in_item_t it;
    it.op      = OP_READ;
    it.gap_us  = 16'($urandom);
    it.channel = ch;
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then update the model.
  // Entered and left at a rising edge.
  task automatic drive_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    n_items++;
    decode_item(it, typed, want);
  endtask

  task automatic send_edge(input logic [WIDTH_BITS-1:0] pw);
    drive_item(edge_item(pw), 1'b0, RES_CLEAN);
  endtask

  task automatic send_read(input logic [CH_W-1:0] ch);
    drive_item(read_item(ch), 1'b0, RES_CLEAN);
  endtask

  // Gap close to the slot's last accepted width, sometimes just past the limit
  function automatic logic [WIDTH_BITS-1:0] near_width(input logic [WIDTH_BITS-1:0] base);
    int j;
    int w;
    j = int'(cfg_q.jitter_limit) - 1;
    if (j < 0) j = 0;
    if ($urandom_range(0, 7) == 0) j = j + 6;
    w = int'(base) + int'($urandom_range(0, 2 * j)) - j;
    if (w < 0) w = 0;
    if (w > 65535) w = 65535;
    return w[WIDTH_BITS-1:0];
  endfunction

  // One PPM frame: sync, channel gaps (usually a full set), then readouts
  task automatic send_frame();
    int hi_off;
    int n_gaps;
    int r;
    if (cfg_q.sync_gap != 16'hFFFF) begin
      hi_off = 65534 - int'(cfg_q.sync_gap);
      if (hi_off > 3000 && $urandom_range(0, 3) != 0) hi_off = 3000;
      send_edge(16'(int'(cfg_q.sync_gap) + 1 + int'($urandom_range(0, hi_off))));
    end
    r = $urandom_range(0, 9);
    n_gaps = (r < 7) ? 8 : ((r < 9) ? $urandom_range(0, 7) : $urandom_range(9, 11));
    for (int i = 0; i < n_gaps; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_edge(16'($urandom_range(800, 2200)));
      end else begin
        send_edge(near_width((fill_idx < CHANNELS) ? last_good[fill_idx] : STICK_CENTER));
      end
      if ($urandom_range(0, 5) == 0) send_read(3'($urandom));
    end
    repeat ($urandom_range(2, 8)) send_read(3'($urandom));
  endtask

  task automatic send_noise();
    in_item_t it;
    repeat ($urandom_range(1, 4)) begin
      it.op      = op_e'($urandom_range(0, 1));
      it.gap_us  = 16'($urandom);
      it.channel = 3'($urandom);
      drive_item(it, 1'b0, RES_CLEAN);
    end
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.sync_gap = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                 16'($urandom_range(2000, 4000));
    c.valid_min = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                  16'($urandom_range(900, 1100));
    c.valid_max = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                  16'($urandom_range(1800, 2100));
    c.jitter_limit = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                     10'($urandom_range(5, 100));
    c.strict_sync = 1'($urandom);
    c.switch_threshold = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                         16'($urandom_range(900, 2100));
    return c;
  endfunction

  // Drop valid and wait for every queued readout, plus a short settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all six registers back to back; unused upper data bits are noise
  task automatic program_regs(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx  [6];
    logic [CFG_DATA_W-1:0] data [6];
    idx[0] = CFG_SYNC_GAP;    data[0] = c.sync_gap;
    idx[1] = CFG_VALID_MIN;   data[1] = c.valid_min;
    idx[2] = CFG_VALID_MAX;   data[2] = c.valid_max;
    idx[3] = CFG_JITTER;      data[3] = {6'($urandom), c.jitter_limit};
    idx[4] = CFG_STRICT_SYNC; data[4] = {15'($urandom), c.strict_sync};
    idx[5] = CFG_SWITCH_THR;  data[5] = c.switch_threshold;
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= data[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_q = c;
  endtask

  // Receiver: random ready with gaps, one long hold-off on request
  initial begin : receiver
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Check each readout transfer against the oldest expectation
  always @(negedge clk_i) begin : readout_check
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      if (readout_q.size() == 0) begin
        $display("%0t: readout with none expected: value %0d fresh %0b frame_error %0b",
                 $time, out_item_o.value, out_item_o.fresh, out_item_o.frame_error);
        n_fail++;
      end else begin
        want = readout_q.pop_front();
        n_checked++;
        if (out_item_o.value !== want.value) begin
          $display("%0t: value mismatch: expected %0d got %0d",
                   $time, want.value, out_item_o.value);
          n_fail++;
        end
        if (out_item_o.fresh !== want.fresh) begin
          $display("%0t: fresh mismatch: expected %0b got %0b",
                   $time, want.fresh, out_item_o.fresh);
          n_fail++;
        end
        if (out_item_o.frame_error !== want.frame_error) begin
          $display("%0t: frame_error mismatch: expected %0b got %0b",
                   $time, want.frame_error, out_item_o.frame_error);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && !in_ready_o) n_stalls++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d readouts outstanding",
                 $time, STALL_LIMIT, readout_q.size());
        $display("FAIL ppm_channel_decoder");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_base;
    int unsigned quota;
    cfg_t        c;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_SYNC_GAP;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_req    = 1'b0;
    reset_model();

    // Directed frame walk under reset settings
    dir_rows = '{
      '{read_item(3'd0), 1'b1, RES_CLEAN},       // empty slot fails the checks
      '{read_item(3'd7), 1'b1, RES_CLEAN},
      '{edge_item(16'd65535), 1'b0, RES_CLEAN},  // early sync, strict: flag only
      '{read_item(3'd3), 1'b1, RES_ERR},
      '{edge_item(16'd1500), 1'b0, RES_CLEAN},
      '{edge_item(16'd1500), 1'b0, RES_CLEAN},
      '{edge_item(16'd1000), 1'b0, RES_CLEAN},
      '{edge_item(16'd1510), 1'b0, RES_CLEAN},
      '{edge_item(16'd990), 1'b0, RES_CLEAN},
      '{edge_item(16'd1001), 1'b0, RES_CLEAN},
      '{edge_item(16'd1000), 1'b0, RES_CLEAN},
      '{edge_item(16'd0), 1'b0, RES_CLEAN},
      '{edge_item(16'd1200), 1'b0, RES_CLEAN},   // slots full: ignored
      '{edge_item(16'd3001), 1'b0, RES_CLEAN},   // complete sync clears the flag
      '{read_item(3'd0), 1'b0, RES_CLEAN},
      '{read_item(3'd1), 1'b0, RES_CLEAN},
      '{read_item(3'd2), 1'b0, RES_CLEAN},
      '{read_item(3'd3), 1'b0, RES_CLEAN},
      '{read_item(3'd4), 1'b0, RES_CLEAN},
      '{read_item(3'd5), 1'b0, RES_CLEAN},
      '{read_item(3'd6), 1'b0, RES_CLEAN},
      '{read_item(3'd7), 1'b1, RES_CLEAN},       // zero width, no role
      '{edge_item(16'd3000), 1'b0, RES_CLEAN},   // equal to sync width: a gap
      '{read_item(3'd0), 1'b0, RES_CLEAN},
      '{edge_item(16'd65535), 1'b0, RES_CLEAN},
      '{read_item(3'd1), 1'b0, RES_CLEAN}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Random frames, one register setting per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: c = CFG_RESET;
        1: c = '{16'd0, 16'd0, 16'hFFFF, 10'h3FF, 1'b0, 16'd0};
        2: c = '{16'hFFFF, 16'hFFFF, 16'd0, 10'd0, 1'b1, 16'hFFFF};
        3: begin
          c = CFG_RESET;
          c.strict_sync = 1'b0;
        end
        default: c = random_cfg();
      endcase
      if (ph > 0) begin
        drain_results();
        program_regs(c);
      end
      tx_idle = (ph != 3 && ph != 4) && ($urandom_range(0, 3) != 0);
      rx_idle = (ph != 4) && ($urandom_range(0, 3) != 0);
      if (ph == 3) hold_req = 1'b1;
      quota = (ph == 1 || ph == 2) ? 60 : 140;
      phase_base = n_items;
      while (n_items - phase_base < quota) begin
        if ($urandom_range(0, 9) < 8) send_frame();
        else send_noise();
      end
    end

    drain_results();
    $display("covered %0d edge and %0d read transfers under %0d register settings",
             n_edges, n_reads, N_PHASES);
    $display("%0d readouts checked (%0d fresh), %0d input stall cycles",
             n_checked, n_fresh, n_stalls);
    if (n_fail == 0) begin
      $display("PASS ppm_channel_decoder");
    end else begin
      $display("FAIL ppm_channel_decoder");
    end
    $finish;
  end

endmodule
